### sv/b64e_pkg.sv
// b64e_pkg: shared types, constants and the alphabet lookup of the base64 encoder
// used by every module of the encoder; depends on nothing

package b64e_pkg;

   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;
   localparam int GROUP_W = 3 * BYTE_W;
   localparam int SEXT_W  = 6;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

   // character slot inside a group, most significant slice first
   typedef enum logic [1:0] {
      SLOT_0 = 2'd0,
      SLOT_1 = 2'd1,
      SLOT_2 = 2'd2,
      SLOT_3 = 2'd3
   } slot_type;

   // one gathered group, as handed from the front to the back
   typedef struct packed {
      logic [GROUP_W-1:0] bits;   // first byte in the top bits
      logic [1:0]         have;   // bytes carried, 1..3
      logic               last;   // group ends the message
   } group_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [CHAR_W-1:0] sext_to_char(input logic [SEXT_W-1:0] sext);
      logic [CHAR_W-1:0] code;
      if (sext < 6'd26) begin
         code = 7'd65 + {1'b0, sext};
      end else if (sext < 6'd52) begin
         code = 7'd71 + {1'b0, sext};
      end else if (sext < 6'd62) begin
         code = {1'b0, sext} - 7'd4;
      end else if (sext == 6'd62) begin
         code = 7'd43;
      end else begin
         code = 7'd47;
      end
      return code;
   endfunction

endpackage

### sv/b64e_front.sv
// b64e_front: takes raw bytes and gathers them into groups of up to three
// depends on b64e_pkg

module b64e_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   output logic                     byte_ready,
   input  logic [b64e_pkg::BYTE_W-1:0] byte_data,
   input  logic                     byte_last,
   output logic                     push,
   output b64e_pkg::group_type      push_group,
   input  logic                     queue_full
);

   logic [2*b64e_pkg::BYTE_W-1:0] held_bytes_ff, held_bytes_in;
   logic [1:0]                    held_count_ff, held_count_in;
   logic                          take;
   logic                          flush;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign flush      = (held_count_ff == 2'd2) || byte_last;
   assign push       = take && flush;

   always_comb begin
      push_group      = '0;
      push_group.last = byte_last;
      held_bytes_in   = held_bytes_ff;
      held_count_in   = held_count_ff;
      unique case (held_count_ff)
         2'd0: begin
            push_group.bits = {byte_data, 16'h0000};
            push_group.have = 2'd1;
         end
         2'd1: begin
            push_group.bits = {held_bytes_ff[15:8], byte_data, 8'h00};
            push_group.have = 2'd2;
         end
         default: begin
            push_group.bits = {held_bytes_ff, byte_data};
            push_group.have = 2'd3;
         end
      endcase
      if (take) begin
         if (flush) begin
            held_bytes_in = '0;
            held_count_in = 2'd0;
         end else begin
            held_bytes_in = push_group.bits[23:8];
            held_count_in = push_group.have;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= 2'd0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

   held_count_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("held byte count out of range");

   no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("group pushed into a full queue");

   held_clear_after_flush: assert property (@(posedge clock) disable iff (reset)
      push |=> (held_count_ff == 2'd0) && (held_bytes_ff == '0))
      else $error("held bytes not cleared after a flush");

endmodule

### sv/b64e_queue.sv
// b64e_queue: short register queue of gathered groups between front and back
// depends on b64e_pkg

module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64e_pkg::group_type push_group,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output b64e_pkg::group_type pop_group
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64e_pkg::group_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_group = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

   pointers_match_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

### sv/b64e_back.sv
// b64e_back: turns one group into four characters, one per cycle unless char_ready stalls the output, with padding
// depends on b64e_pkg

module b64e_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        group_valid,
   input  b64e_pkg::group_type         group_in,
   output logic                        pop,
   output logic                        char_valid,
   input  logic                        char_ready,
   output logic [b64e_pkg::CHAR_W-1:0] char_code,
   output logic                        char_last
);

   b64e_pkg::group_type              cur_ff, cur_in;
   b64e_pkg::slot_type               slot_ff, slot_in;
   logic                             busy_ff, busy_in;
   logic                             out_valid_ff, out_valid_in;
   logic [b64e_pkg::CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                             out_last_ff, out_last_in;
   logic                             load;
   logic [b64e_pkg::SEXT_W-1:0]      sext;
   logic                             pad;

   assign load = busy_ff && (!out_valid_ff || char_ready);
   assign pop  = group_valid && (!busy_ff || (load && slot_ff == b64e_pkg::SLOT_3));

   always_comb begin
      unique case (slot_ff)
         b64e_pkg::SLOT_0: sext = cur_ff.bits[23:18];
         b64e_pkg::SLOT_1: sext = cur_ff.bits[17:12];
         b64e_pkg::SLOT_2: sext = cur_ff.bits[11:6];
         b64e_pkg::SLOT_3: sext = cur_ff.bits[5:0];
         default:          sext = cur_ff.bits[5:0];
      endcase
      // slots beyond the bytes carried are padding
      pad = ({1'b0, slot_ff} > {1'b0, cur_ff.have});
   end

   always_comb begin
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sext_to_char(sext);
         out_last_in  = cur_ff.last && (slot_ff == b64e_pkg::SLOT_3);
         slot_in      = b64e_pkg::slot_type'(slot_ff + 2'd1);
         if (slot_ff == b64e_pkg::SLOT_3) begin
            busy_in = 1'b0;
         end
      end else if (char_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         cur_in  = group_in;
         slot_in = b64e_pkg::SLOT_0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= b64e_pkg::SLOT_0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign char_valid = out_valid_ff;
   assign char_code  = out_char_ff;
   assign char_last  = out_last_ff;

   idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (slot_ff == b64e_pkg::SLOT_0))
      else $error("slot counter not parked while idle");

   busy_group_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.have != 2'd0))
      else $error("group under way carries no bytes");

   pad_never_first: assert property (@(posedge clock) disable iff (reset)
      (load && (slot_ff == b64e_pkg::SLOT_0 || slot_ff == b64e_pkg::SLOT_1)) |-> !pad)
      else $error("padding in a slot that always holds data");

endmodule

### sv/base64_stream_encoder_core.sv
// base64_stream_encoder_core: top level of the base64 stream encoder
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
//  channel   dir  handshake          payload
//  req_      in   tvalid / tready    tdata[7:0] data_byte, tlast last_byte
//  rsp_      out  tvalid / tready    tdata[6:0] out_char (bit 7 zero), tlast last_char
//
// the front takes a byte in any cycle the group queue has room; every third byte,
// or a byte with tlast, closes a group and pushes it into the queue
// the back emits one character per cycle from a registered output stage unless rsp_tready
// stalls it, so each group of up to three bytes leaves as four characters
// a closed group goes through a queue entry, then the back's group register and output register
// reset is synchronous and clears held bytes, queue pointers and the output valid
// a stall on rsp_ fills the queue, after which req_tready drops

module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero
   output logic       rsp_tlast     // last_char
);

   // group hand-over between front and queue
   logic                push;
   b64e_pkg::group_type push_group;
   logic                queue_full;

   // group hand-over between queue and back
   logic                pop;
   logic                queue_not_empty;
   b64e_pkg::group_type pop_group;

   logic [b64e_pkg::CHAR_W-1:0] char_code;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .push       (push),
      .push_group (push_group),
      .queue_full (queue_full)
   );

   // QUEUE_DEPTH groups of slack, two by default, so front and back stall independently
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_group  (pop_group)
   );

   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .group_valid (queue_not_empty),
      .group_in    (pop_group),
      .pop         (pop),
      .char_valid  (rsp_tvalid),
      .char_ready  (rsp_tready),
      .char_code   (char_code),
      .char_last   (rsp_tlast)
   );

   // ascii fits in seven bits, top bit of the byte stays zero
   assign rsp_tdata = {1'b0, char_code};

endmodule
